@@ hdl/lsac_pkg.sv @@
// Shared codes and control types for the set-associative cache tag model.
`default_nettype none

package lsac_pkg;

  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS  = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } lsac_cmd_t;

  typedef struct packed {
    logic clear_last;
  } lsac_sts_t;

endpackage

`default_nettype wire

@@ hdl/lsac_ctrl.sv @@
// Controller: clearing pass, word acceptance, lookup commit and output valid.
`default_nettype none

module lsac_ctrl
  import lsac_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output lsac_cmd_t      cmd,
  input  wire lsac_sts_t sts
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_comb begin
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.commit = (state_r == ST_LOOKUP) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.clear_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (cmd.commit) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_load_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_LOOKUP))
    else $error("load not followed by lookup");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result shown without a commit");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result pending during clearing pass");

endmodule

`default_nettype wire

@@ hdl/lsac_dp.sv @@
// Datapath: configuration, address split, tag store, LRU lookup and counters.
`default_nettype none

module lsac_dp
  import lsac_pkg::*;
#(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [1:0]             in_func,
  input  wire logic [63:0]            in_address,
  input  wire lsac_cmd_t              cmd,
  output lsac_sts_t                   sts,
  output logic                        out_was_hit,
  output logic                        out_was_evicted,
  output logic [1:0]                  out_hits_added,
  output logic [31:0]                 out_hit_total,
  output logic [31:0]                 out_miss_total,
  output logic [31:0]                 out_eviction_total
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int LINE_W = 1 + AGE_W + ADDR_WIDTH;
  localparam int ROW_W  = MAX_WAYS * LINE_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  logic [2:0]              set_bits_r;
  logic [3:0]              ways_r;
  logic [5:0]              block_bits_r;
  logic [2:0]              sb_eff;
  logic [WCNT_W-1:0]       w_eff;

  logic [ADDR_WIDTH-1:0]   addr_m;
  logic [ADDR_WIDTH-1:0]   set_shift;
  logic [SET_W-1:0]        set_mask;
  logic [SET_W-1:0]        set_idx;
  logic [6:0]              tag_shamt;
  logic [ADDR_WIDTH-1:0]   tag_in;

  logic [ROW_W-1:0]        mem [MAX_SETS];
  logic [ROW_W-1:0]        rd_row_r;
  logic [ROW_W-1:0]        new_row;
  logic [SET_W-1:0]        clr_ptr_r;
  logic [SET_W-1:0]        set_r;
  logic [ADDR_WIDTH-1:0]   tag_r;
  logic [1:0]              func_r;

  logic                    v   [MAX_WAYS];
  logic [AGE_W-1:0]        age [MAX_WAYS];
  logic [ADDR_WIDTH-1:0]   tg  [MAX_WAYS];

  logic                    hit;
  logic                    free_fnd;
  logic                    evict;
  logic                    modify;
  logic [AGE_W-1:0]        hit_way;
  logic [AGE_W-1:0]        free_way;
  logic [AGE_W-1:0]        old_way;
  logic [AGE_W-1:0]        oldest;
  logic [AGE_W-1:0]        tgt;

  logic [31:0]             hit_cnt_r;
  logic [31:0]             miss_cnt_r;
  logic [31:0]             evict_cnt_r;
  logic                    was_hit_r;
  logic                    was_evicted_r;
  logic [1:0]              hits_added_r;

  // Configuration registers and their effective values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd0;
      ways_r       <= 4'd1;
      block_bits_r <= 6'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:    set_bits_r   <= cfg_wdata[2:0];
        REG_WAYS_IN_USE: ways_r       <= cfg_wdata[3:0];
        REG_BLOCK_BITS:  block_bits_r <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (int'(set_bits_r) > SB_MAX) begin
      sb_eff = 3'(SB_MAX);
    end else begin
      sb_eff = set_bits_r;
    end
    if (ways_r == 4'd0) begin
      w_eff = WCNT_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      w_eff = WCNT_W'(MAX_WAYS);
    end else begin
      w_eff = WCNT_W'(ways_r);
    end
  end

  // Address split into set index and tag.
  always_comb begin
    addr_m    = in_address[ADDR_WIDTH-1:0];
    set_shift = addr_m >> block_bits_r;
    set_mask  = SET_W'((1 << sb_eff) - 1);
    set_idx   = SET_W'(set_shift) & set_mask;
    tag_shamt = 7'(block_bits_r) + 7'(sb_eff);
    tag_in    = addr_m >> tag_shamt;
  end

  // Tag store: one row per set holding every way.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_ptr_r] <= '0;
    end else if (cmd.commit) begin
      mem[set_r] <= new_row;
    end
    if (cmd.load) begin
      rd_row_r <= mem[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else if (cmd.clear) begin
      clr_ptr_r <= clr_ptr_r + SET_W'(1);
    end
  end

  assign sts.clear_last = (clr_ptr_r == SET_W'(MAX_SETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r  <= set_idx;
      tag_r  <= tag_in;
      func_r <= in_func;
    end
  end

  // Lookup, victim choice and recency update.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      tg[i]  = rd_row_r[i*LINE_W +: ADDR_WIDTH];
      age[i] = rd_row_r[i*LINE_W + ADDR_WIDTH +: AGE_W];
      v[i]   = rd_row_r[i*LINE_W + LINE_W - 1];
    end
  end

  always_comb begin
    hit      = 1'b0;
    free_fnd = 1'b0;
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    oldest   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (int'(w_eff) > i) begin
        if (v[i] && (tg[i] == tag_r) && !hit) begin
          hit     = 1'b1;
          hit_way = AGE_W'(i);
        end
        if (!v[i] && !free_fnd) begin
          free_fnd = 1'b1;
          free_way = AGE_W'(i);
        end
        if (age[i] > oldest) begin
          oldest  = age[i];
          old_way = AGE_W'(i);
        end
      end
    end
    evict = !hit && !free_fnd;
    if (hit) begin
      tgt = hit_way;
    end else if (free_fnd) begin
      tgt = free_way;
    end else begin
      tgt = old_way;
    end
    modify = (func_r == FUNC_MODIFY);
  end

  always_comb begin
    new_row = rd_row_r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (AGE_W'(i) == tgt) begin
        new_row[i*LINE_W +: LINE_W] = {1'b1, {AGE_W{1'b0}}, tag_r};
      end else if ((int'(w_eff) > i) && v[i] && (age[i] != AGE_MAX) &&
                   ((!hit && free_fnd) || (age[i] < age[tgt]))) begin
        new_row[i*LINE_W + ADDR_WIDTH +: AGE_W] = age[i] + AGE_W'(1);
      end
    end
  end

  // Running totals and the result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.commit) begin
      hit_cnt_r   <= hit_cnt_r + 32'(hit) + 32'(modify);
      miss_cnt_r  <= miss_cnt_r + 32'(!hit);
      evict_cnt_r <= evict_cnt_r + 32'(evict);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      was_hit_r     <= hit;
      was_evicted_r <= evict;
      hits_added_r  <= 2'(hit) + 2'(modify);
    end
  end

  assign out_was_hit        = was_hit_r;
  assign out_was_evicted    = was_evicted_r;
  assign out_hits_added     = hits_added_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

  a_hit_excludes_evict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(hit && evict))
    else $error("hit and eviction in one lookup");

  a_evict_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && evict) |=> (evict_cnt_r == $past(evict_cnt_r) + 32'd1))
    else $error("eviction not counted");

endmodule

`default_nettype wire

@@ hdl/lru_set_assoc_cache_tag_model.sv @@
// Top level of the set-associative cache tag model with LRU replacement.
// Each access first reads the selected set's row from the tag store into a register, then
// compares the tags, chooses the victim, writes the row back and updates the totals.
// The lookup waits while an earlier result word is still held on the output, and a new
// access is taken while a finished result waits. After reset a clearing pass writes every
// set's row, during which no access is taken; configuration writes are accepted at any
// time the block is idle.
`default_nettype none

module lru_set_assoc_cache_tag_model
  import lsac_pkg::*;
#(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_func,
  input  wire logic [63:0]            in_address,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_was_hit,
  output logic                        out_was_evicted,
  output logic [1:0]                  out_hits_added,
  output logic [31:0]                 out_hit_total,
  output logic [31:0]                 out_miss_total,
  output logic [31:0]                 out_eviction_total
);

  lsac_cmd_t cmd;
  lsac_sts_t sts;

  lsac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lsac_dp #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_func            (in_func),
    .in_address         (in_address),
    .cmd                (cmd),
    .sts                (sts),
    .out_was_hit        (out_was_hit),
    .out_was_evicted    (out_was_evicted),
    .out_hits_added     (out_hits_added),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

endmodule

`default_nettype wire
